>>> hdl/jfss_pkg.sv
// Shared types and constants for the JPEG frame size scanner.
// Depends on nothing; every other file in hdl imports it.
`timescale 1ns / 1ps

package jfss_pkg;

  typedef logic [2:0] status_t;

  localparam status_t STATUS_FOUND     = 3'd0;
  localparam status_t STATUS_ZERO_DIM  = 3'd1;
  localparam status_t STATUS_BAD_HDR   = 3'd2;
  localparam status_t STATUS_NO_FRAME  = 3'd3;
  localparam status_t STATUS_BAD_LEN   = 3'd4;
  localparam status_t STATUS_TRUNCATED = 3'd5;

  localparam logic [7:0] MARK_PREFIX  = 8'hFF;
  localparam logic [7:0] MARK_SOI     = 8'hD8;
  localparam logic [7:0] MARK_EOI     = 8'hD9;
  localparam logic [7:0] MARK_SOS     = 8'hDA;
  localparam logic [7:0] MARK_RST_LO  = 8'hD0;
  localparam logic [7:0] MARK_RST_HI  = 8'hD7;
  localparam logic [7:0] MARK_SOF_LO  = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI  = 8'hCF;
  localparam logic [7:0] MARK_DHT     = 8'hC4;
  localparam logic [7:0] MARK_JPG     = 8'hC8;
  localparam logic [7:0] MARK_DAC     = 8'hCC;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       at_end;
    logic       starts_file;
  } jfss_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } jfss_out_t;

endpackage

>>> hdl/jfss_parser.sv
// Byte-wise marker parser: holds the parse phase and segment counters and
// works out the file's result word. Depends on jfss_pkg.
`timescale 1ns / 1ps

module jfss_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  jfss_pkg::jfss_in_t  in_data,
  output logic                res_valid,
  output jfss_pkg::jfss_out_t res_data
);
  import jfss_pkg::*;

  typedef enum logic [3:0] {
    PH_DONE    = 4'd0,
    PH_SOI_HI  = 4'd1,
    PH_SOI_LO  = 4'd2,
    PH_HUNT    = 4'd3,
    PH_MARKER  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_SKIP    = 4'd7,
    PH_FLEN_HI = 4'd8,
    PH_FLEN_LO = 4'd9,
    PH_PREC    = 4'd10,
    PH_H_HI    = 4'd11,
    PH_H_LO    = 4'd12,
    PH_W_HI    = 4'd13,
    PH_W_LO    = 4'd14
  } phase_t;

  phase_t      phase, phase_next, cur;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [7:0]  held_high_byte, held_high_byte_next;
  logic [15:0] frame_height, frame_height_next;

  logic        finish;
  logic [7:0]  b;
  logic        at_end;
  logic [15:0] word16;
  logic        is_frame;
  logic        is_restart;

  assign b          = in_data.file_byte;
  assign at_end     = in_data.at_end;
  assign word16     = {held_high_byte, b};
  assign is_frame   = (b >= MARK_SOF_LO) && (b <= MARK_SOF_HI) &&
                      (b != MARK_DHT) && (b != MARK_JPG) && (b != MARK_DAC);
  assign is_restart = (b >= MARK_RST_LO) && (b <= MARK_RST_HI);

  always_comb begin
    cur                 = in_data.starts_file ? PH_SOI_HI : phase;
    phase_next          = cur;
    skip_remaining_next = skip_remaining;
    held_high_byte_next = held_high_byte;
    frame_height_next   = frame_height;
    finish              = 1'b0;
    res_data            = '0;
    unique case (cur)
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      PH_SOI_HI: begin
        if (at_end || b != MARK_PREFIX) begin
          finish          = 1'b1;
          res_data.status = STATUS_BAD_HDR;
        end else begin
          phase_next = PH_SOI_LO;
        end
      end
      PH_SOI_LO: begin
        if (at_end || b != MARK_SOI) begin
          finish          = 1'b1;
          res_data.status = STATUS_BAD_HDR;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_HUNT: begin
        if (at_end) begin
          finish          = 1'b1;
          res_data.status = STATUS_NO_FRAME;
        end else if (b == MARK_PREFIX) begin
          phase_next = PH_MARKER;
        end
      end
      PH_MARKER: begin
        if (at_end || b == MARK_EOI || b == MARK_SOS) begin
          finish          = 1'b1;
          res_data.status = STATUS_NO_FRAME;
        end else if (b == MARK_PREFIX) begin
          phase_next = PH_MARKER;
        end else if (is_restart) begin
          phase_next = PH_HUNT;
        end else begin
          phase_next = is_frame ? PH_FLEN_HI : PH_LEN_HI;
        end
      end
      PH_LEN_HI, PH_FLEN_HI: begin
        if (at_end) begin
          finish          = 1'b1;
          res_data.status = STATUS_BAD_LEN;
        end else begin
          held_high_byte_next = b;
          phase_next          = (cur == PH_LEN_HI) ? PH_LEN_LO : PH_FLEN_LO;
        end
      end
      PH_LEN_LO, PH_FLEN_LO: begin
        if (at_end || word16[15:1] == 15'd0) begin
          finish          = 1'b1;
          res_data.status = STATUS_BAD_LEN;
        end else if (cur == PH_FLEN_LO) begin
          phase_next = PH_PREC;
        end else begin
          skip_remaining_next = word16 - 16'd2;
          phase_next = (word16 == 16'd2) ? PH_HUNT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (at_end) begin
          finish          = 1'b1;
          res_data.status = STATUS_NO_FRAME;
        end else begin
          skip_remaining_next = skip_remaining - 16'd1;
          if (skip_remaining == 16'd1) begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_PREC: begin
        if (at_end) begin
          finish          = 1'b1;
          res_data.status = STATUS_TRUNCATED;
        end else begin
          phase_next = PH_H_HI;
        end
      end
      PH_H_HI, PH_W_HI: begin
        if (at_end) begin
          finish          = 1'b1;
          res_data.status = STATUS_TRUNCATED;
        end else begin
          held_high_byte_next = b;
          phase_next          = (cur == PH_H_HI) ? PH_H_LO : PH_W_LO;
        end
      end
      PH_H_LO: begin
        if (at_end) begin
          finish          = 1'b1;
          res_data.status = STATUS_TRUNCATED;
        end else begin
          frame_height_next = word16;
          phase_next        = PH_W_HI;
        end
      end
      PH_W_LO: begin
        finish = 1'b1;
        if (at_end) begin
          res_data.status = STATUS_TRUNCATED;
        end else begin
          res_data.image_width  = word16;
          res_data.image_height = frame_height;
          res_data.status = (word16 != 16'd0 && frame_height != 16'd0) ?
                            STATUS_FOUND : STATUS_ZERO_DIM;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
    if (finish) begin
      phase_next = PH_DONE;
    end
  end

  assign res_valid = accept && finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      skip_remaining <= '0;
      held_high_byte <= '0;
      frame_height   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      skip_remaining <= skip_remaining_next;
      held_high_byte <= held_high_byte_next;
      frame_height   <= frame_height_next;
    end
  end

`ifndef ASSERT_OFF
  // Every result closes the file until the next start.
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == PH_DONE)
    else $error("parser not idle after a result");

  // The skip phase always has body bytes left to consume.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != 16'd0)
    else $error("skip phase with nothing to skip");

  // A found frame never carries a zero dimension.
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == STATUS_FOUND) |->
      (res_data.image_width != 16'd0 && res_data.image_height != 16'd0))
    else $error("found status with zero dimension");
`endif

endmodule

>>> hdl/jfss_out_buf.sv
// Two-entry result buffer (output register plus skid register) that keeps
// the parser running while the consumer stalls. Depends on jfss_pkg.
`timescale 1ns / 1ps

module jfss_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jfss_pkg::jfss_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output jfss_pkg::jfss_out_t out_data
);
  import jfss_pkg::*;

  logic      skid_valid;
  jfss_out_t skid_data;
  logic      pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      // A push only arrives while the skid register is empty.
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
          out_data  <= push_data;
        end else begin
          skid_valid <= 1'b1;
          skid_data  <= push_data;
        end
      end else if (pop) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (out_valid && !skid_valid))
    else $error("skid word not moved forward on pop");
`endif

endmodule

>>> hdl/jpeg_frame_size_scanner_unit.sv
// Top level of the JPEG frame size scanner.
// Depends on jfss_pkg, jfss_parser and jfss_out_buf.
`timescale 1ns / 1ps

// The scanner takes one file byte per cycle and gives at most one result word
// per file, holding the status and the frame dimensions from the first frame
// header. Each byte is processed by the combinational phase logic; the
// result word for the byte (or end mark) that settles the outcome is registered
// in the output buffer. Results pass through a two-entry buffer, so in_ready
// falls only when two results are waiting on a stalled consumer; otherwise a
// byte is accepted on every clock. Bytes sent with no file open are dropped
// silently until a word flagged starts_file arrives.
module jpeg_frame_size_scanner_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jfss_pkg::jfss_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jfss_pkg::jfss_out_t out_data
);
  import jfss_pkg::*;

  logic      accept;
  logic      res_valid;
  jfss_out_t res_data;
  logic      buf_full;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  jfss_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  jfss_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_jpeg_frame_size_scanner_unit.sv
// Testbench for jpeg_frame_size_scanner_unit: byte streams of whole, broken and noisy files
// go in, and every result word is checked against a predictor kept in step here.
// Depends on jfss_pkg and the scanner RTL in hdl.
`timescale 1ns / 1ps

module tb_jpeg_frame_size_scanner_unit;
  import jfss_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int WORDS_PER_PHASE = 440;

  typedef enum logic [3:0] {
    PH_DONE, PH_SOI_HI, PH_SOI_LO, PH_HUNT, PH_MARKER, PH_LEN_HI, PH_LEN_LO, PH_SKIP,
    PH_FLEN_HI, PH_FLEN_LO, PH_PREC, PH_H_HI, PH_H_LO, PH_W_HI, PH_W_LO
  } scan_phase_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  jfss_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  jfss_out_t out_data;

  jfss_in_t  pending_words[$];
  jfss_in_t  file_words[$];
  jfss_out_t size_reports_due[$];
  jfss_out_t oldest_report;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_words = 0;
  int accepted_words = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Predictor state.
  scan_phase_t phase_q = PH_DONE;
  logic [15:0] skip_left = '0;
  logic [7:0]  high_byte = '0;
  logic [15:0] height_seen = '0;

  jpeg_frame_size_scanner_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic is_frame_marker(logic [7:0] m);
    return m >= MARK_SOF_LO && m <= MARK_SOF_HI && m != MARK_DHT && m != MARK_JPG &&
           m != MARK_DAC;
  endfunction

  function automatic void report_size(status_t st, logic [15:0] w, logic [15:0] h);
    jfss_out_t r;
    r.status       = st;
    r.image_width  = w;
    r.image_height = h;
    size_reports_due.push_back(r);
    phase_q = PH_DONE;
  endfunction

  function automatic void scan_word(jfss_in_t w);
    logic [7:0]  b;
    logic [15:0] value;
    b = w.file_byte;
    if (w.starts_file) begin
      phase_q = PH_SOI_HI;
      skip_left = '0;
      high_byte = '0;
      height_seen = '0;
    end
    value = {high_byte, b};
    case (phase_q)
      PH_SOI_HI: begin
        if (w.at_end || b != MARK_PREFIX) report_size(STATUS_BAD_HDR, '0, '0);
        else phase_q = PH_SOI_LO;
      end
      PH_SOI_LO: begin
        if (w.at_end || b != MARK_SOI) report_size(STATUS_BAD_HDR, '0, '0);
        else phase_q = PH_HUNT;
      end
      PH_HUNT: begin
        if (w.at_end) report_size(STATUS_NO_FRAME, '0, '0);
        else if (b == MARK_PREFIX) phase_q = PH_MARKER;
      end
      PH_MARKER: begin
        if (w.at_end || b == MARK_EOI || b == MARK_SOS) begin
          report_size(STATUS_NO_FRAME, '0, '0);
        end else if (b == MARK_PREFIX) begin
          // Fill bytes keep the marker search where it is.
        end else if (b >= MARK_RST_LO && b <= MARK_RST_HI) begin
          phase_q = PH_HUNT;
        end else begin
          phase_q = is_frame_marker(b) ? PH_FLEN_HI : PH_LEN_HI;
        end
      end
      PH_LEN_HI, PH_FLEN_HI: begin
        if (w.at_end) begin
          report_size(STATUS_BAD_LEN, '0, '0);
        end else begin
          high_byte = b;
          phase_q = (phase_q == PH_LEN_HI) ? PH_LEN_LO : PH_FLEN_LO;
        end
      end
      PH_LEN_LO, PH_FLEN_LO: begin
        if (w.at_end || value < 16'd2) begin
          report_size(STATUS_BAD_LEN, '0, '0);
        end else if (phase_q == PH_FLEN_LO) begin
          phase_q = PH_PREC;
        end else begin
          skip_left = value - 16'd2;
          phase_q = (skip_left == '0) ? PH_HUNT : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (w.at_end) begin
          report_size(STATUS_NO_FRAME, '0, '0);
        end else begin
          skip_left = skip_left - 16'd1;
          if (skip_left == '0) phase_q = PH_HUNT;
        end
      end
      PH_PREC: begin
        if (w.at_end) report_size(STATUS_TRUNCATED, '0, '0);
        else phase_q = PH_H_HI;
      end
      PH_H_HI, PH_W_HI: begin
        if (w.at_end) begin
          report_size(STATUS_TRUNCATED, '0, '0);
        end else begin
          high_byte = b;
          phase_q = (phase_q == PH_H_HI) ? PH_H_LO : PH_W_LO;
        end
      end
      PH_H_LO: begin
        if (w.at_end) begin
          report_size(STATUS_TRUNCATED, '0, '0);
        end else begin
          height_seen = value;
          phase_q = PH_W_HI;
        end
      end
      PH_W_LO: begin
        if (w.at_end) report_size(STATUS_TRUNCATED, '0, '0);
        else report_size((value != '0 && height_seen != '0) ? STATUS_FOUND : STATUS_ZERO_DIM,
                         value, height_seen);
      end
      default: phase_q = PH_DONE;
    endcase
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function automatic void queue_word(jfss_in_t w);
    pending_words.push_back(w);
    queued_words++;
  endfunction

  // The first word of a file under construction carries the start flag.
  function automatic void add_word(logic [7:0] b, logic at_end);
    file_words.push_back('{file_byte: b, at_end: at_end, starts_file: file_words.size() == 0});
  endfunction

  function automatic void ship_file();
    foreach (file_words[i]) queue_word(file_words[i]);
    file_words.delete();
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // Driver: a new word is offered once the previous one has gone or none was offered.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_word(in_data);
        accepted_words++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (size_reports_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: status %0d width %0d height %0d", $time,
                   out_data.status, out_data.image_width, out_data.image_height);
        end else begin
          oldest_report = size_reports_due.pop_front();
          check_field("status", 16'(oldest_report.status), 16'(out_data.status));
          check_field("image_width", oldest_report.image_width, out_data.image_width);
          check_field("image_height", oldest_report.image_height, out_data.image_height);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (accepted_words == queued_words && size_reports_due.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_jpeg_frame_size_scanner_unit NOT OK");
      $finish;
    end
  end

  initial begin
    int          target;
    int          cut;
    int          body;
    logic        stop;
    logic [7:0]  mark;
    logic [15:0] seg_len;
    logic [15:0] dim;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Words with no file open are dropped.
    queue_word('{file_byte: MARK_PREFIX, at_end: 1'b0, starts_file: 1'b0});
    queue_word('{file_byte: 8'h00, at_end: 1'b1, starts_file: 1'b0});
    // An empty file, then a file whose first byte is wrong.
    add_word(8'h5A, 1'b1);
    ship_file();
    add_word(8'h00, 1'b0);
    ship_file();
    // A segment with no body, fill bytes, a restart marker and a frame header at full size.
    add_word(MARK_PREFIX, 1'b0);
    add_word(MARK_SOI, 1'b0);
    add_word(MARK_PREFIX, 1'b0);
    add_word(8'hFE, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h02, 1'b0);
    add_word(MARK_PREFIX, 1'b0);
    add_word(MARK_PREFIX, 1'b0);
    add_word(8'hD3, 1'b0);
    add_word(MARK_PREFIX, 1'b0);
    add_word(MARK_SOF_LO, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'h08, 1'b0);
    repeat (4) add_word(8'hFF, 1'b0);
    ship_file();
    // End of image before any frame header.
    add_word(MARK_PREFIX, 1'b0);
    add_word(MARK_SOI, 1'b0);
    add_word(MARK_PREFIX, 1'b0);
    add_word(MARK_EOI, 1'b0);
    ship_file();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      target = queued_words + WORDS_PER_PHASE;
      while (queued_words < target) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 6))
            queue_word('{file_byte: 8'($urandom_range(255)), at_end: $urandom_range(3) == 0,
                         starts_file: $urandom_range(2) == 0});
        end else begin
          stop = 1'b0;
          add_word(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : MARK_PREFIX, 1'b0);
          add_word(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : MARK_SOI, 1'b0);
          repeat ($urandom_range(3)) begin
            if (!stop) begin
              case ($urandom_range(4))
                0: repeat ($urandom_range(1, 4)) add_word(8'($urandom_range(254)), 1'b0);
                1: begin
                  repeat ($urandom_range(1, 3)) add_word(MARK_PREFIX, 1'b0);
                  add_word(8'($urandom_range(MARK_RST_LO, MARK_RST_HI)), 1'b0);
                end
                default: begin
                  case ($urandom_range(5))
                    0: mark = MARK_DHT;
                    1: mark = MARK_JPG;
                    2: mark = MARK_DAC;
                    default: begin
                      do mark = 8'($urandom_range(255));
                      while (mark == MARK_PREFIX || (mark >= MARK_RST_LO && mark <= MARK_SOS) ||
                             is_frame_marker(mark));
                    end
                  endcase
                  add_word(MARK_PREFIX, 1'b0);
                  add_word(mark, 1'b0);
                  case ($urandom_range(9))
                    0: seg_len = 16'($urandom_range(1));
                    1: seg_len = 16'($urandom_range(16'hFFFF));
                    default: seg_len = 16'($urandom_range(2, 12));
                  endcase
                  add_word(seg_len[15:8], 1'b0);
                  add_word(seg_len[7:0], 1'b0);
                  if (seg_len < 16'd2) begin
                    stop = 1'b1;
                  end else begin
                    // Long bodies are cut short and the file is ended or abandoned inside them.
                    body = int'(seg_len - 16'd2);
                    if (body > 12) begin
                      body = $urandom_range(12);
                      stop = 1'b1;
                    end
                    repeat (body) add_word(8'($urandom_range(255)), 1'b0);
                  end
                end
              endcase
            end
          end
          if (!stop) begin
            case ($urandom_range(9))
              0: begin
                add_word(MARK_PREFIX, 1'b0);
                add_word(MARK_EOI, 1'b0);
              end
              1: begin
                add_word(MARK_PREFIX, 1'b0);
                add_word(MARK_SOS, 1'b0);
              end
              2: begin
                // Left open; an end mark or the next file closes it.
              end
              default: begin
                do mark = 8'($urandom_range(MARK_SOF_LO, MARK_SOF_HI));
                while (!is_frame_marker(mark));
                add_word(MARK_PREFIX, 1'b0);
                add_word(mark, 1'b0);
                case ($urandom_range(7))
                  0: seg_len = 16'($urandom_range(1));
                  1: seg_len = 16'($urandom_range(2, 16'hFFFF));
                  default: seg_len = 16'd17;
                endcase
                add_word(seg_len[15:8], 1'b0);
                add_word(seg_len[7:0], 1'b0);
                add_word(8'($urandom_range(255)), 1'b0);
                dim = pick_dim();
                add_word(dim[15:8], 1'b0);
                add_word(dim[7:0], 1'b0);
                dim = pick_dim();
                add_word(dim[15:8], 1'b0);
                add_word(dim[7:0], 1'b0);
              end
            endcase
          end
          if ($urandom_range(4) == 0 && file_words.size() > 1) begin
            cut = $urandom_range(1, file_words.size() - 1);
            while (file_words.size() > cut) file_words.delete(file_words.size() - 1);
          end
          if ($urandom_range(3) != 0) add_word(8'($urandom_range(255)), 1'b1);
          ship_file();
          if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3))
              queue_word('{file_byte: 8'($urandom_range(255)), at_end: 1'($urandom_range(1)),
                           starts_file: 1'b0});
          end
        end
      end
      while (accepted_words != queued_words) @(posedge clk);
    end

    while (accepted_words != queued_words || size_reports_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && size_reports_due.size() == 0) begin
      $display("tb_jpeg_frame_size_scanner_unit OK");
    end else begin
      $display("tb_jpeg_frame_size_scanner_unit NOT OK");
    end
    $finish;
  end

endmodule
